/* src/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// Rate limit table package
// Shared constants and types for the per-client rate limit table.
// ----------------------------------------------------------------------------
`default_nettype none
package rlt_pkg;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int NUM_RULES_DEF   = 4;
  localparam int IP_W    = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int RULE_W  = 2;
  localparam int CFG_AW  = 5;

  localparam logic [2:0] REG_LIMIT0  = 3'd0;
  localparam logic [2:0] REG_LIMIT1  = 3'd1;
  localparam logic [2:0] REG_LIMIT2  = 3'd2;
  localparam logic [2:0] REG_LIMIT3  = 3'd3;
  localparam logic [2:0] REG_SAFE0   = 3'd4;
  localparam logic [2:0] REG_SAFE1   = 3'd5;
  localparam logic [2:0] REG_SAFECNT = 3'd6;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [RULE_W-1:0] rule;
    logic [CNT_W-1:0]  hits;
    logic [TIME_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic [4*32-1:0]  limits;
    logic [IP_W-1:0]  safe0;
    logic [IP_W-1:0]  safe1;
    logic [1:0]       safe_cnt;
  } cfg_t;
endpackage
`default_nettype wire

/* src/rlt_cfg.sv */
// ----------------------------------------------------------------------------
// Rate limit table configuration registers
// APB register file for rule limits and exempt addresses.
// ----------------------------------------------------------------------------
`default_nettype none
module rlt_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [rlt_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output rlt_pkg::cfg_t                  cfg
);
  logic [31:0] lim_r [4];
  logic [31:0] safe0_r, safe1_r;
  logic [1:0]  scnt_r;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) lim_r[i] <= '0;
      safe0_r <= '0;
      safe1_r <= '0;
      scnt_r  <= '0;
    end else if (wr) begin
      case (idx)
        rlt_pkg::REG_LIMIT0:  lim_r[0] <= pwdata;
        rlt_pkg::REG_LIMIT1:  lim_r[1] <= pwdata;
        rlt_pkg::REG_LIMIT2:  lim_r[2] <= pwdata;
        rlt_pkg::REG_LIMIT3:  lim_r[3] <= pwdata;
        rlt_pkg::REG_SAFE0:   safe0_r  <= pwdata;
        rlt_pkg::REG_SAFE1:   safe1_r  <= pwdata;
        rlt_pkg::REG_SAFECNT: scnt_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rlt_pkg::REG_LIMIT0:  prdata = lim_r[0];
      rlt_pkg::REG_LIMIT1:  prdata = lim_r[1];
      rlt_pkg::REG_LIMIT2:  prdata = lim_r[2];
      rlt_pkg::REG_LIMIT3:  prdata = lim_r[3];
      rlt_pkg::REG_SAFE0:   prdata = safe0_r;
      rlt_pkg::REG_SAFE1:   prdata = safe1_r;
      rlt_pkg::REG_SAFECNT: prdata = {30'd0, scnt_r};
      default:              prdata = '0;
    endcase
  end

  assign cfg.limits   = {lim_r[3], lim_r[2], lim_r[1], lim_r[0]};
  assign cfg.safe0    = safe0_r;
  assign cfg.safe1    = safe1_r;
  assign cfg.safe_cnt = scnt_r;
endmodule
`default_nettype wire

/* src/rlt_mul.sv */
// ----------------------------------------------------------------------------
// Rate limit table shared multiplier
// Registered 33x16 product used for both sides of the rate compare.
// ----------------------------------------------------------------------------
`default_nettype none
module rlt_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [15:0] b,
  output logic      [48:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 49'(a) * 49'(b);
  end
endmodule
`default_nettype wire

/* src/per_client_rate_limit_table_top.sv */
// ----------------------------------------------------------------------------
// Per-client rate limit table
// Fixed-window request counter per (address, rule) with block reporting.
// ----------------------------------------------------------------------------
// Timing: an ignored request goes straight to the closing beat; a counted one
//   searches the table for each hit rule and then sweeps every used entry,
//   paced by the one-entry-per-cycle table port and the shared multiplier (two
//   products per swept entry), and waits on out_tready for each block report.
// Throughput: one request at a time; in_tready is low while it is worked.
// Reset: synchronous, active low; the table is empty and the state, pointer and config registers are zero.
`default_nettype none
module per_client_rate_limit_table_top #(
  parameter int TABLE_DEPTH = rlt_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_RULES   = rlt_pkg::NUM_RULES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // client_ip, now_seconds
  input  wire logic [3:0]  in_tuser,   // rule_hits
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,  // blocked_ip, blocked_rule, blocked_count, pad
  output logic             out_tuser,  // block_valid
  output logic             out_tlast,  // last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [rlt_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RULE  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_SWRD  = 4'd4;
  localparam logic [3:0] S_SWM1  = 4'd5;
  localparam logic [3:0] S_SWM2  = 4'd6;
  localparam logic [3:0] S_SWDEC = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_CLOSE = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;

  rlt_pkg::cfg_t cfg;

  rlt_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  rlt_pkg::entry_t mem [TABLE_DEPTH];
  rlt_pkg::entry_t rd_r;

  logic [3:0]  st_r;
  logic [CW-1:0] used_r, idx_r, wp_r;
  logic [31:0] ip_r, now_r;
  logic [3:0]  hits_r;
  logic [1:0]  rule_r;
  logic [32:0] ma;
  logic [15:0] mb;
  logic [48:0] prod;
  logic [48:0] lhs_r;
  logic        we;
  logic [IW-1:0] wa, ra;
  rlt_pkg::entry_t wd;

  rlt_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  logic [31:0] lim;
  logic [15:0] win;
  logic [32:0] endt;
  logic        elapsed;
  logic        safe_hit;
  logic [3:0]  hmask;

  assign lim  = cfg.limits[32*rd_r.rule +: 32];
  assign win  = (lim[15:0] == 16'd0) ? 16'd1 : lim[15:0];
  assign endt = {1'b0, rd_r.start} + {17'd0, win};
  assign elapsed = {1'b0, now_r} >= endt;
  assign hmask = in_tuser & 4'((1 << NUM_RULES) - 1);
  assign safe_hit = (cfg.safe_cnt != 2'd0 && cfg.safe0 == in_tdata[31:0]) ||
                    (cfg.safe_cnt[1] && cfg.safe1 == in_tdata[31:0]);

  assign ra = idx_r[IW-1:0];

  always_comb begin
    ma = {17'd0, rd_r.hits};
    mb = win;
    if (st_r == S_SWM1) begin
      ma = {1'b0, now_r - rd_r.start};
      mb = lim[31:16];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = wp_r[IW-1:0];
    wd = rd_r;
    if (st_r == S_CHK) begin
      if (idx_r < used_r && rd_r.ip == ip_r && rd_r.rule == rule_r) begin
        we = 1'b1;
        wa = idx_r[IW-1:0];
        wd.hits = (rd_r.hits == 16'hFFFF) ? rd_r.hits : rd_r.hits + 16'd1;
      end else if (idx_r >= used_r && used_r < CW'(TABLE_DEPTH)) begin
        we = 1'b1;
        wa = used_r[IW-1:0];
        wd.ip = ip_r; wd.rule = rule_r; wd.hits = 16'd1; wd.start = now_r;
      end
    end else if (st_r == S_SWDEC && !elapsed) begin
      we = (wp_r != idx_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      idx_r <= '0;
      wp_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_tvalid) begin
          ip_r   <= in_tdata[31:0];
          now_r  <= in_tdata[63:32];
          hits_r <= hmask;
          rule_r <= 2'd0;
          st_r   <= (safe_hit || hmask == 4'd0) ? S_CLOSE : S_RULE;
        end
        S_RULE: begin
          if (rule_r == 2'(NUM_RULES - 1) && !hits_r[rule_r]) begin
            idx_r <= '0; wp_r <= '0; st_r <= S_SRD;
          end else if (!hits_r[rule_r]) rule_r <= rule_r + 2'd1;
          else begin
            idx_r <= '0; st_r <= S_SRCH;
          end
        end
        S_SRCH: st_r <= S_CHK;
        S_CHK: begin
          if ((idx_r < used_r && rd_r.ip == ip_r && rd_r.rule == rule_r) ||
              idx_r >= used_r) begin
            if (idx_r >= used_r && used_r < CW'(TABLE_DEPTH)) used_r <= used_r + 1'b1;
            hits_r[rule_r] <= 1'b0;
            st_r <= S_RULE;
          end else begin
            idx_r <= idx_r + 1'b1; st_r <= S_SRCH;
          end
        end
        S_SRD: st_r <= (idx_r < used_r) ? S_SWM1 : S_CLOSE;
        S_SWM1: st_r <= S_SWM2;
        S_SWM2: begin lhs_r <= prod; st_r <= S_SWDEC; end
        S_SWDEC: begin
          if (elapsed && prod >= lhs_r) st_r <= S_OUT;
          else begin
            if (!elapsed) wp_r <= wp_r + 1'b1;
            idx_r <= idx_r + 1'b1;
            st_r <= S_SWRD;
          end
        end
        S_OUT: if (out_tready) begin
          idx_r <= idx_r + 1'b1; st_r <= S_SWRD;
        end
        S_SWRD: st_r <= S_SRD;
        S_CLOSE: if (out_tready) begin
          if (hits_r == 4'd0 && rule_r != 2'd0 || wp_r != '0 || idx_r != '0)
            used_r <= wp_r;
          idx_r <= '0; wp_r <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT) || (st_r == S_CLOSE);
  assign out_tlast  = (st_r == S_CLOSE);
  assign out_tuser  = (st_r == S_OUT);
  assign out_tdata  = (st_r == S_OUT) ?
                      {6'd0, rd_r.hits, rd_r.rule, rd_r.ip} : 56'd0;

  ap_one_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both active");
  ap_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH)) else $error("table overfilled");
  ap_wp: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= idx_r) else $error("compaction pointer ahead");
endmodule
`default_nettype wire
